FILE: hw/rtl/ectp_pkg.sv
// ectp_pkg: shared types and constants of the request frame tag-length-value parser
// no dependencies; used by the interfaces, all parser modules and the checker

package ectp_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ECM     = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_UNKNOWN = 2'd2
    } kind_t;

    // command and tag codes
    localparam logic [7:0] CMD_ECM_REQ = 8'd1;
    localparam logic [7:0] TAG_CAID_HI = 8'd2;
    localparam logic [7:0] TAG_ECM     = 8'd3;
    localparam logic [7:0] TAG_PROVID  = 8'd6;
    localparam logic [7:0] TAG_CAID    = 8'd10;

    // ecm header: 12-bit length from value bytes 1-2 plus the three header bytes
    localparam logic [3:0]  ECM_LEN_HI_MASK = 4'hF;
    localparam logic [12:0] ECM_HDR_BYTES   = 13'd3;

    // at most six trailing provid digits are kept
    localparam logic [7:0] PROVID_MAX_CHARS = 8'd6;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one queue entry: up to three ecm bytes, then an optional summary or unknown result
    typedef struct packed {
        logic [1:0]      ecm_cnt;
        logic [2:0][7:0] ecm_bytes;
        logic [7:0]      ecm_off;
        logic            tail_valid;
        kind_t           tail_kind;
        logic [15:0]     caid;
        logic [23:0]     provid;
        logic [7:0]      ecm_length;
        logic            corrupt;
        logic [7:0]      command;
    } entry_t;

endpackage

FILE: hw/rtl/ectp_if.sv
// ectp_frame_if and ectp_result_if: valid/ready channels of the parser
// depends on ectp_pkg for the result kind type

interface ectp_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_start;

    modport source (output valid, output frame_byte, output frame_start, input ready);
    modport sink   (input valid, input frame_byte, input frame_start, output ready);
endinterface

interface ectp_result_if;
    logic                 valid;
    logic                 ready;
    ectp_pkg::kind_t      kind;
    logic [7:0]           ecm_byte;
    logic [7:0]           ecm_offset;
    logic [15:0]          caid;
    logic [23:0]          provid;
    logic [7:0]           ecm_length;
    logic                 corrupt;
    logic [7:0]           command;
    logic                 last;

    modport source (output valid, output kind, output ecm_byte, output ecm_offset,
                    output caid, output provid, output ecm_length, output corrupt,
                    output command, output last, input ready);
    modport sink   (input valid, input kind, input ecm_byte, input ecm_offset,
                    input caid, input provid, input ecm_length, input corrupt,
                    input command, input last, output ready);
endinterface

FILE: hw/rtl/ectp_front.sv
// ectp_front: frame byte intake, tag walk and result classification into queue entries
// depends on ectp_pkg and ectp_frame_if

module ectp_front #(
    parameter int MAX_ECM_BYTES = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    ectp_frame_if.sink       frame,
    input  logic             q_full,
    output logic             push,
    output ectp_pkg::entry_t entry
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN,
        PH_BODY,
        PH_UNKNOWN,
        PH_DONE
    } phase_t;

    localparam logic [12:0] MaxEcmLen = 13'(MAX_ECM_BYTES);

    // returns {is_digit, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c inside {[8'h30:8'h39]}) begin
                d = c - 8'h30;
                hex_digit = {1'b1, d[3:0]};
            end else if (c inside {[8'h41:8'h46]}) begin
                d = c - 8'h37;
                hex_digit = {1'b1, d[3:0]};
            end else if (c inside {[8'h61:8'h66]}) begin
                d = c - 8'h57;
                hex_digit = {1'b1, d[3:0]};
            end else begin
                hex_digit = 5'd0;
            end
        end
    endfunction

    phase_t      phase_reg,        phase_next;
    logic [7:0]  command_reg,      command_next;
    logic [7:0]  body_len_reg,     body_len_next;
    logic [7:0]  body_pos_reg,     body_pos_next;
    logic [7:0]  tag_type_reg,     tag_type_next;
    logic [8:0]  next_tag_reg,     next_tag_next;
    logic        await_len_reg,    await_len_next;
    logic [3:0]  hdr_ecm_reg,      hdr_ecm_next;
    logic [3:0]  hdr_caid_reg,     hdr_caid_next;
    logic [3:0]  hdr_caid_hi_reg,  hdr_caid_hi_next;
    logic [15:0] head_reg,         head_next;
    logic        ecm_active_reg,   ecm_active_next;
    logic [7:0]  ecm_count_reg,    ecm_count_next;
    logic [7:0]  ecm_rem_reg,      ecm_rem_next;
    logic [7:0]  ecm_len_reg,      ecm_len_next;
    logic [15:0] caid_reg,         caid_next;
    logic [23:0] digits_reg,       digits_next;
    logic [23:0] provid_reg,       provid_next;
    logic        prid_active_reg,  prid_active_next;
    logic        prid_bad_reg,     prid_bad_next;
    logic [7:0]  prid_start_reg,   prid_start_next;
    logic [7:0]  prid_end_reg,     prid_end_next;

    logic accept;

    assign frame.ready = !q_full;
    assign accept      = frame.valid && frame.ready;

    always_comb
    begin
        logic [7:0]  b;
        logic [7:0]  prev1;
        logic [7:0]  prev2;
        logic [8:0]  pos1;
        logic [12:0] ecm_len13;
        logic        restart;
        logic        cur_hdr;
        logic [4:0]  hv;
        logic        bad;
        logic [23:0] digits;
        logic [8:0]  tag_end;
        logic [1:0]  ndig;

        b         = frame.frame_byte;
        prev1     = head_reg[7:0];
        prev2     = head_reg[15:8];
        pos1      = {1'b0, body_pos_reg} + 9'd1;
        ecm_len13 = {1'b0, prev1[3:0] & ectp_pkg::ECM_LEN_HI_MASK, b} +
                    ectp_pkg::ECM_HDR_BYTES;
        restart   = 1'b0;
        cur_hdr   = 1'b0;
        hv        = 5'd0;
        bad       = 1'b0;
        digits    = 24'd0;
        tag_end   = 9'd0;
        ndig      = 2'd0;

        phase_next       = phase_reg;
        command_next     = command_reg;
        body_len_next    = body_len_reg;
        body_pos_next    = body_pos_reg;
        tag_type_next    = tag_type_reg;
        next_tag_next    = next_tag_reg;
        await_len_next   = await_len_reg;
        hdr_ecm_next     = hdr_ecm_reg;
        hdr_caid_next    = hdr_caid_reg;
        hdr_caid_hi_next = hdr_caid_hi_reg;
        head_next        = head_reg;
        ecm_active_next  = ecm_active_reg;
        ecm_count_next   = ecm_count_reg;
        ecm_rem_next     = ecm_rem_reg;
        ecm_len_next     = ecm_len_reg;
        caid_next        = caid_reg;
        digits_next      = digits_reg;
        provid_next      = provid_reg;
        prid_active_next = prid_active_reg;
        prid_bad_next    = prid_bad_reg;
        prid_start_next  = prid_start_reg;
        prid_end_next    = prid_end_reg;

        entry = '0;
        entry.tail_kind = ectp_pkg::KIND_SUMMARY;

        if (accept) begin
            if (frame.frame_start) begin
                // a new frame aborts anything in progress
                phase_next       = PH_LEN;
                command_next     = b;
                body_len_next    = 8'd0;
                body_pos_next    = 8'd0;
                tag_type_next    = 8'd0;
                next_tag_next    = 9'd0;
                await_len_next   = 1'b0;
                hdr_ecm_next     = 4'd0;
                hdr_caid_next    = 4'd0;
                hdr_caid_hi_next = 4'd0;
                head_next        = 16'd0;
                ecm_active_next  = 1'b0;
                ecm_count_next   = 8'd0;
                ecm_rem_next     = 8'd0;
                ecm_len_next     = 8'd0;
                caid_next        = 16'd0;
                digits_next      = 24'd0;
                provid_next      = 24'd0;
                prid_active_next = 1'b0;
                prid_bad_next    = 1'b0;
                prid_start_next  = 8'd0;
                prid_end_next    = 8'd0;
            end else begin
                case (phase_reg)
                    PH_LEN:
                    begin
                        body_len_next = b;
                        body_pos_next = 8'd0;
                        if (b == 8'd0)
                            phase_next = PH_DONE;
                        else if (command_reg == ectp_pkg::CMD_ECM_REQ)
                            phase_next = PH_BODY;
                        else
                            phase_next = PH_UNKNOWN;
                    end
                    PH_UNKNOWN:
                    begin
                        entry.tail_valid = 1'b1;
                        entry.tail_kind  = ectp_pkg::KIND_UNKNOWN;
                        entry.command    = command_reg;
                        phase_next       = PH_DONE;
                    end
                    PH_BODY:
                    begin
                        // ecm header complete: tag 3 started four bytes back
                        if (hdr_ecm_reg[3]) begin
                            if (ecm_len13 <= MaxEcmLen &&
                                ({5'd0, body_pos_reg} - 13'd2) + ecm_len13
                                    <= {5'd0, body_len_reg}) begin
                                restart           = 1'b1;
                                entry.ecm_cnt     = 2'd3;
                                entry.ecm_bytes   = {b, prev1, prev2};
                                entry.ecm_off     = 8'd0;
                                ecm_len_next      = ecm_len13[7:0];
                                ecm_count_next    = 8'd3;
                                ecm_rem_next      = ecm_len13[7:0] - 8'd3;
                                ecm_active_next   = (ecm_len13[7:0] != 8'd3);
                            end
                        end
                        if (!restart && ecm_active_reg) begin
                            entry.ecm_cnt      = 2'd1;
                            entry.ecm_bytes[0] = b;
                            entry.ecm_off      = ecm_count_reg;
                            ecm_count_next     = ecm_count_reg + 8'd1;
                            ecm_rem_next       = ecm_rem_reg - 8'd1;
                            if (ecm_rem_reg == 8'd1)
                                ecm_active_next = 1'b0;
                        end

                        // caid bytes at fixed offsets from the tag start
                        if (hdr_caid_reg[2])
                            caid_next = {prev1, b};
                        if (hdr_caid_hi_reg[1])
                            caid_next = {b, 8'h00};

                        if (prid_active_reg && body_pos_reg >= prid_start_reg) begin
                            hv     = hex_digit(b);
                            bad    = prid_bad_reg | !hv[4];
                            digits = hv[4] ? {digits_reg[19:0], hv[3:0]} : digits_reg;
                            prid_bad_next = bad;
                            digits_next   = digits;
                            if (pos1 == {1'b0, prid_end_reg}) begin
                                provid_next      = bad ? 24'd0 : digits;
                                prid_active_next = 1'b0;
                            end
                        end

                        if (await_len_reg) begin
                            tag_end        = next_tag_reg + {1'b0, b} + 9'd2;
                            next_tag_next  = tag_end;
                            await_len_next = 1'b0;
                            if (tag_type_reg == ectp_pkg::TAG_PROVID &&
                                tag_end <= {1'b0, body_len_reg}) begin
                                ndig = (b > ectp_pkg::PROVID_MAX_CHARS) ? 2'd3 : b[2:1];
                                if (ndig == 2'd0) begin
                                    provid_next = 24'd0;
                                end else begin
                                    prid_active_next = 1'b1;
                                    prid_bad_next    = 1'b0;
                                    digits_next      = 24'd0;
                                    prid_start_next  = tag_end[7:0] - {5'd0, ndig, 1'b0};
                                    prid_end_next    = tag_end[7:0];
                                end
                            end
                        end else if ({1'b0, body_pos_reg} == next_tag_reg &&
                                     pos1 < {1'b0, body_len_reg}) begin
                            tag_type_next  = b;
                            await_len_next = 1'b1;
                            cur_hdr        = 1'b1;
                        end

                        hdr_ecm_next     = {hdr_ecm_reg[2:0],
                                            cur_hdr && b == ectp_pkg::TAG_ECM};
                        hdr_caid_next    = {hdr_caid_reg[2:0],
                                            cur_hdr && b == ectp_pkg::TAG_CAID};
                        hdr_caid_hi_next = {hdr_caid_hi_reg[2:0],
                                            cur_hdr && b == ectp_pkg::TAG_CAID_HI};
                        head_next        = {prev1, b};

                        if (pos1 >= {1'b0, body_len_reg}) begin
                            entry.tail_valid = 1'b1;
                            entry.tail_kind  = ectp_pkg::KIND_SUMMARY;
                            entry.caid       = caid_next;
                            entry.provid     = provid_next;
                            entry.ecm_length = ecm_len_next;
                            entry.corrupt    = (next_tag_next != {1'b0, body_len_reg});
                            phase_next       = PH_DONE;
                        end else begin
                            body_pos_next = pos1[7:0];
                        end
                    end
                    default:
                    begin
                        // stray bytes outside a frame are dropped
                    end
                endcase
            end
        end

        push = (entry.ecm_cnt != 2'd0) || entry.tail_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg       <= PH_IDLE;
            command_reg     <= 8'd0;
            body_len_reg    <= 8'd0;
            body_pos_reg    <= 8'd0;
            tag_type_reg    <= 8'd0;
            next_tag_reg    <= 9'd0;
            await_len_reg   <= 1'b0;
            hdr_ecm_reg     <= 4'd0;
            hdr_caid_reg    <= 4'd0;
            hdr_caid_hi_reg <= 4'd0;
            head_reg        <= 16'd0;
            ecm_active_reg  <= 1'b0;
            ecm_count_reg   <= 8'd0;
            ecm_rem_reg     <= 8'd0;
            ecm_len_reg     <= 8'd0;
            caid_reg        <= 16'd0;
            digits_reg      <= 24'd0;
            provid_reg      <= 24'd0;
            prid_active_reg <= 1'b0;
            prid_bad_reg    <= 1'b0;
            prid_start_reg  <= 8'd0;
            prid_end_reg    <= 8'd0;
        end else begin
            phase_reg       <= phase_next;
            command_reg     <= command_next;
            body_len_reg    <= body_len_next;
            body_pos_reg    <= body_pos_next;
            tag_type_reg    <= tag_type_next;
            next_tag_reg    <= next_tag_next;
            await_len_reg   <= await_len_next;
            hdr_ecm_reg     <= hdr_ecm_next;
            hdr_caid_reg    <= hdr_caid_next;
            hdr_caid_hi_reg <= hdr_caid_hi_next;
            head_reg        <= head_next;
            ecm_active_reg  <= ecm_active_next;
            ecm_count_reg   <= ecm_count_next;
            ecm_rem_reg     <= ecm_rem_next;
            ecm_len_reg     <= ecm_len_next;
            caid_reg        <= caid_next;
            digits_reg      <= digits_next;
            provid_reg      <= provid_next;
            prid_active_reg <= prid_active_next;
            prid_bad_reg    <= prid_bad_next;
            prid_start_reg  <= prid_start_next;
            prid_end_reg    <= prid_end_next;
        end
    end

endmodule

FILE: hw/rtl/ectp_queue.sv
// ectp_queue: short entry queue between the front and back of the parser
// depends on ectp_pkg for the entry type and depth

module ectp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ectp_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output ectp_pkg::entry_t head,
    output logic             empty
);

    localparam int AW = ectp_pkg::QUEUE_AW;

    ectp_pkg::entry_t mem [ectp_pkg::QUEUE_DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg,  count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == (AW+1)'(ectp_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/ectp_back.sv
// ectp_back: unpacks queue entries into single results behind an output register
// depends on ectp_pkg and ectp_result_if

module ectp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  ectp_pkg::entry_t head,
    input  logic             empty,
    output logic             pop,
    ectp_result_if.source    result
);

    logic [1:0]          idx_reg, idx_next;
    logic                valid_reg, valid_next;
    ectp_pkg::kind_t     kind_reg;
    logic [7:0]          ecm_byte_reg;
    logic [7:0]          ecm_offset_reg;
    logic [15:0]         caid_reg;
    logic [23:0]         provid_reg;
    logic [7:0]          ecm_length_reg;
    logic                corrupt_reg;
    logic [7:0]          command_reg;
    logic                last_reg;

    logic       load;
    logic       is_ecm;
    logic       is_last;
    logic [2:0] total;

    assign total   = {1'b0, head.ecm_cnt} + {2'b00, head.tail_valid};
    assign is_ecm  = idx_reg < head.ecm_cnt;
    assign is_last = ({1'b0, idx_reg} + 3'd1) == total;
    // output register refills from a non-empty queue whenever it is empty or being taken
    assign load    = !empty && (!valid_reg || result.ready);
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
        if (load)
            valid_next = 1'b1;
        else if (result.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            last_reg <= is_last;
            if (is_ecm) begin
                kind_reg       <= ectp_pkg::KIND_ECM;
                ecm_byte_reg   <= head.ecm_bytes[idx_reg];
                ecm_offset_reg <= head.ecm_off + {6'd0, idx_reg};
                caid_reg       <= 16'd0;
                provid_reg     <= 24'd0;
                ecm_length_reg <= 8'd0;
                corrupt_reg    <= 1'b0;
                command_reg    <= 8'd0;
            end else begin
                kind_reg       <= head.tail_kind;
                ecm_byte_reg   <= 8'd0;
                ecm_offset_reg <= 8'd0;
                caid_reg       <= head.caid;
                provid_reg     <= head.provid;
                ecm_length_reg <= head.ecm_length;
                corrupt_reg    <= head.corrupt;
                command_reg    <= head.command;
            end
        end
    end

    assign result.valid      = valid_reg;
    assign result.kind       = kind_reg;
    assign result.ecm_byte   = ecm_byte_reg;
    assign result.ecm_offset = ecm_offset_reg;
    assign result.caid       = caid_reg;
    assign result.provid     = provid_reg;
    assign result.ecm_length = ecm_length_reg;
    assign result.corrupt    = corrupt_reg;
    assign result.command    = command_reg;
    assign result.last       = last_reg;

endmodule

FILE: hw/rtl/ecm_request_tlv_parser_core.sv
// ecm_request_tlv_parser_core: top level of the request frame tag-length-value parser
// depends on ectp_pkg, ectp_if, ectp_front, ectp_queue and ectp_back
//
// usage
//   frame:  one byte per transaction; frame_start marks the command byte, then the body
//           length byte, then the tag-length-value body
//   result: ecm bytes as they arrive, then one summary per command-1 frame with a
//           non-empty body, or one unknown-command result for any other command
//           with a non-empty body; last flags the final result that a given frame byte caused
// timing
//   an accepted byte is classified combinationally and its entry is written into the
//   queue; its results then pass through the output register to the result channel
//   one byte per cycle is taken while the queue has room; a byte that completes an
//   in-range ecm header gives three results and the last body byte adds a summary,
//   so up to four results per byte; a four-entry queue between intake and output
//   absorbs those bursts, and frame.ready drops only while that queue is full
// reset
//   rst_n clears the tag walk, the queue and the output register; the block waits
//   for a byte with frame_start set
// stalls
//   while result.ready is low the output register holds its transaction, the queue
//   fills and then frame.ready goes low until results drain

module ecm_request_tlv_parser_core #(
    parameter int MAX_ECM_BYTES = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    ectp_frame_if.sink    frame,
    ectp_result_if.source result
);

    ectp_pkg::entry_t push_entry;
    ectp_pkg::entry_t head;
    logic             push;
    logic             full;
    logic             pop;
    logic             empty;

    ectp_front #(
        .MAX_ECM_BYTES (MAX_ECM_BYTES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame),
        .q_full (full),
        .push   (push),
        .entry  (push_entry)
    );

    ectp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    ectp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

FILE: hw/rtl/ectp_checker.sv
// ectp_checker: port-level assertions on the parser result channel, bound to the top level
// depends on ectp_pkg and ecm_request_tlv_parser_core

module ectp_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            res_valid,
    input logic            res_ready,
    input ectp_pkg::kind_t res_kind,
    input logic [7:0]      res_ecm_byte,
    input logic [7:0]      res_ecm_offset,
    input logic [15:0]     res_caid,
    input logic [23:0]     res_provid,
    input logic [7:0]      res_ecm_length,
    input logic            res_corrupt,
    input logic [7:0]      res_command,
    input logic            res_last
);

    // stalled transaction holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind) &&
            $stable(res_ecm_byte) && $stable(res_ecm_offset) && $stable(res_last))
        else $error("result changed while stalled");

    // summary and unknown-command results close the run of a byte
    a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind != ectp_pkg::KIND_ECM |-> res_last)
        else $error("non-ecm result without last");

    a_tail_no_ecm: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind != ectp_pkg::KIND_ECM |->
            res_ecm_byte == 8'd0 && res_ecm_offset == 8'd0)
        else $error("ecm fields set on non-ecm result");

    a_ecm_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == ectp_pkg::KIND_ECM |->
            res_caid == 16'd0 && res_provid == 24'd0 && res_ecm_length == 8'd0 &&
            !res_corrupt && res_command == 8'd0)
        else $error("summary fields set on ecm result");

    a_unknown_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == ectp_pkg::KIND_UNKNOWN |->
            res_caid == 16'd0 && res_provid == 24'd0 && res_ecm_length == 8'd0 &&
            !res_corrupt)
        else $error("summary fields set on unknown-command result");

endmodule

bind ecm_request_tlv_parser_core ectp_checker u_ectp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_kind       (result.kind),
    .res_ecm_byte   (result.ecm_byte),
    .res_ecm_offset (result.ecm_offset),
    .res_caid       (result.caid),
    .res_provid     (result.provid),
    .res_ecm_length (result.ecm_length),
    .res_corrupt    (result.corrupt),
    .res_command    (result.command),
    .res_last       (result.last)
);
